// File: hdl/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
// Depends on nothing; used by the front, back and top modules.
`default_nettype none

package bbc_pkg;

   localparam int STACK_DEPTH_DEF = 128;
   localparam int FIFO_DEPTH      = 4;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_OROUND = 8'h28;
   localparam logic [7:0] CHAR_CROUND = 8'h29;
   localparam logic [7:0] CHAR_OCURLY = 8'h7B;
   localparam logic [7:0] CHAR_CCURLY = 8'h7D;
   localparam logic [7:0] CHAR_OSQUARE = 8'h5B;
   localparam logic [7:0] CHAR_CSQUARE = 8'h5D;

   localparam logic [1:0] KIND_ROUND  = 2'd0;
   localparam logic [1:0] KIND_CURLY  = 2'd1;
   localparam logic [1:0] KIND_SQUARE = 2'd2;

   localparam logic [1:0] OP_END  = 2'd0;
   localparam logic [1:0] OP_PUSH = 2'd1;
   localparam logic [1:0] OP_POP  = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] kind;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type entry;
   } head_type;

endpackage

`default_nettype wire

// File: hdl/bracket_balance_checker_top.sv
// Verdict path: an accepted zero byte is queued, and its verdict beat is registered once
// it reaches the head of the queue and the verdict register is free.
// Throughput: one character per cycle while the queue has room; the stack takes one push or pop a cycle,
// its top held in a register and the entry beneath prefetched from the RAM.
// A held verdict stalls only the next end of string; the 4-entry queue absorbs the rest.
// Reset: synchronous, active high; clears depth, flags, queue and valid; stack RAM uncleared.
// Depends on bbc_pkg, bbc_front, bbc_back and bbc_ram.
`default_nettype none

module bracket_balance_checker_top #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_character,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_balanced,
   output logic            rsp_overflowed
);

   bbc_pkg::head_type head;
   logic              deq;

   bbc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .head          (head),
      .deq           (deq)
   );

   bbc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .deq            (deq),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_balanced   (rsp_balanced),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule

`default_nettype wire

// File: hdl/bbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/bbc_front.sv
// Front end: accepts characters, classifies them and queues stack operations.
// Depends on bbc_pkg.
`default_nettype none

module bbc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_character,
   output bbc_pkg::head_type      head,
   input  wire logic              deq
);

   localparam int PW = $clog2(bbc_pkg::FIFO_DEPTH);
   localparam int CW = $clog2(bbc_pkg::FIFO_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(bbc_pkg::FIFO_DEPTH);

   bbc_pkg::op_type fifo_ff [bbc_pkg::FIFO_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   bbc_pkg::op_type cls;
   logic            cls_keep;
   logic            accept;
   logic            enq;

   always_comb begin
      cls.op   = bbc_pkg::OP_END;
      cls.kind = bbc_pkg::KIND_ROUND;
      cls_keep = 1'b1;
      case (req_character)
         bbc_pkg::CHAR_NUL: begin
            cls.op = bbc_pkg::OP_END;
         end
         bbc_pkg::CHAR_OROUND: begin
            cls.op = bbc_pkg::OP_PUSH;
         end
         bbc_pkg::CHAR_OCURLY: begin
            cls.op   = bbc_pkg::OP_PUSH;
            cls.kind = bbc_pkg::KIND_CURLY;
         end
         bbc_pkg::CHAR_OSQUARE: begin
            cls.op   = bbc_pkg::OP_PUSH;
            cls.kind = bbc_pkg::KIND_SQUARE;
         end
         bbc_pkg::CHAR_CROUND: begin
            cls.op = bbc_pkg::OP_POP;
         end
         bbc_pkg::CHAR_CCURLY: begin
            cls.op   = bbc_pkg::OP_POP;
            cls.kind = bbc_pkg::KIND_CURLY;
         end
         bbc_pkg::CHAR_CSQUARE: begin
            cls.op   = bbc_pkg::OP_POP;
            cls.kind = bbc_pkg::KIND_SQUARE;
         end
         default: begin
            cls_keep = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == FULL_COUNT);
   assign accept    = req_valid && !req_stall;
   assign enq       = accept && cls_keep;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = PW'((CW'(wr_ptr_ff) + CW'(1)) % CW'(bbc_pkg::FIFO_DEPTH));
      end
      if (deq) begin
         rd_ptr_in = PW'((CW'(rd_ptr_ff) + CW'(1)) % CW'(bbc_pkg::FIFO_DEPTH));
      end
      if (enq && !deq) begin
         count_in = count_ff + CW'(1);
      end else if (deq && !enq) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         fifo_ff[wr_ptr_ff] <= cls;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = fifo_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");

   a_no_deq_empty: assert property (@(posedge clock) disable iff (reset)
      deq |-> count_ff != '0)
      else $error("dequeue from empty queue");

   a_end_queued: assert property (@(posedge clock) disable iff (reset)
      (accept && req_character == bbc_pkg::CHAR_NUL && !deq)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("end of string not queued");

endmodule

`default_nettype wire

// File: hdl/bbc_back.sv
// Back end: runs queued push, pop and end operations on the bracket stack
// and holds the verdict beat. Depends on bbc_pkg and bbc_ram.
`default_nettype none

module bbc_back #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  bbc_pkg::head_type      head,
   output logic                   deq,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_balanced,
   output logic                   rsp_overflowed
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);

   logic [DW-1:0] depth_ff, depth_in;
   logic [1:0]    tos_ff, tos_in;
   logic          mis_ff, mis_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          bal_ff, bal_in;
   logic          ovfo_ff, ovfo_in;
   logic          rsp_free;
   logic          wr_en;
   logic [DW-1:0] rd_depth;
   logic [1:0]    below;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign deq      = head.valid && (head.entry.op != bbc_pkg::OP_END || rsp_free);

   always_comb begin
      depth_in     = depth_ff;
      tos_in       = tos_ff;
      mis_in       = mis_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      bal_in       = bal_ff;
      ovfo_in      = ovfo_ff;
      if (deq) begin
         case (head.entry.op)
            bbc_pkg::OP_PUSH: begin
               if (depth_ff == FULL_DEPTH) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  depth_in = depth_ff + DW'(1);
                  tos_in   = head.entry.kind;
               end
            end
            bbc_pkg::OP_POP: begin
               if (depth_ff == '0) begin
                  mis_in = 1'b1;
               end else begin
                  depth_in = depth_ff - DW'(1);
                  tos_in   = below;
                  if (tos_ff != head.entry.kind) begin
                     mis_in = 1'b1;
                  end
               end
            end
            bbc_pkg::OP_END: begin
               rsp_valid_in = 1'b1;
               bal_in       = !mis_ff && !ovf_ff && (depth_ff == '0);
               ovfo_in      = ovf_ff;
               depth_in     = '0;
               mis_in       = 1'b0;
               ovf_in       = 1'b0;
            end
            default: begin
               depth_in = depth_ff;
            end
         endcase
      end
   end

   // keep the entry under the new top on the read port
   assign rd_depth = depth_in - DW'(2);

   bbc_ram #(
      .WIDTH (2),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (head.entry.kind),
      .rd_addr (rd_depth[AW-1:0]),
      .rd_data (below)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         mis_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         mis_ff       <= mis_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff  <= tos_in;
      bal_ff  <= bal_in;
      ovfo_ff <= ovfo_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_balanced   = bal_ff;
   assign rsp_overflowed = ovfo_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= FULL_DEPTH)
      else $error("stack depth beyond limit");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (deq && head.entry.op == bbc_pkg::OP_END)
      |=> depth_ff == '0 && !mis_ff && !ovf_ff && rsp_valid_ff)
      else $error("end of string did not clear state");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (deq && head.entry.op == bbc_pkg::OP_POP && depth_ff == '0)
      |=> mis_ff && depth_ff == '0)
      else $error("pop on empty stack not flagged");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (deq && head.entry.op == bbc_pkg::OP_PUSH && depth_ff == FULL_DEPTH)
      |=> ovf_ff && depth_ff == FULL_DEPTH)
      else $error("push on full stack not flagged");

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for bracket_balance_checker_top: a directed table and deep nests, then random strings,
// checked beat by beat against an in-bench bracket stack model or the table's typed verdicts.
// Depends on bbc_pkg and the checker RTL only.

module tb;

   localparam int NEST_LIMIT  = bbc_pkg::STACK_DEPTH_DEF;
   localparam int ITEM_BUDGET = 1600;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic balanced;
      logic overflowed;
   } verdict_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       typed;
      logic       balanced;
      logic       overflowed;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_character = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_balanced;
   logic       rsp_overflowed;

   logic [1:0] held_kind [NEST_LIMIT];
   int         held_count = 0;
   logic       clash_seen = 1'b0;
   logic       spill_seen = 1'b0;

   verdict_type verdicts [$];
   int         errors = 0;
   int         beats_sent = 0;
   int         send_idle_pct = 11;
   int         rcv_idle_pct = 63;
   logic       hold_req = 1'b0;
   int         hold_left = 0;

   row_type plan [0:23] = '{
      '{bbc_pkg::CHAR_NUL,     1'b1, 1'b1, 1'b0},
      '{bbc_pkg::CHAR_OROUND,  1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_CROUND,  1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_NUL,     1'b1, 1'b1, 1'b0},
      '{bbc_pkg::CHAR_OCURLY,  1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_OSQUARE, 1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_CSQUARE, 1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_CCURLY,  1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_NUL,     1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_CROUND,  1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_NUL,     1'b1, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_OROUND,  1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_CSQUARE, 1'b0, 1'b0, 1'b0},
      '{8'h61,                 1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_NUL,     1'b1, 1'b0, 1'b0},
      '{8'hFF,                 1'b0, 1'b0, 1'b0},
      '{8'h01,                 1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_NUL,     1'b1, 1'b1, 1'b0},
      '{bbc_pkg::CHAR_CCURLY,  1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_OSQUARE, 1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_CSQUARE, 1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_NUL,     1'b1, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_OROUND,  1'b0, 1'b0, 1'b0},
      '{bbc_pkg::CHAR_NUL,     1'b1, 1'b0, 1'b0}
   };

   bracket_balance_checker_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_balanced  (rsp_balanced),
      .rsp_overflowed(rsp_overflowed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit opener_kind(input logic [7:0] c, output logic [1:0] k);
      k = bbc_pkg::KIND_ROUND;
      case (c)
         bbc_pkg::CHAR_OROUND:  k = bbc_pkg::KIND_ROUND;
         bbc_pkg::CHAR_OCURLY:  k = bbc_pkg::KIND_CURLY;
         bbc_pkg::CHAR_OSQUARE: k = bbc_pkg::KIND_SQUARE;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic bit closer_kind(input logic [7:0] c, output logic [1:0] k);
      k = bbc_pkg::KIND_ROUND;
      case (c)
         bbc_pkg::CHAR_CROUND:  k = bbc_pkg::KIND_ROUND;
         bbc_pkg::CHAR_CCURLY:  k = bbc_pkg::KIND_CURLY;
         bbc_pkg::CHAR_CSQUARE: k = bbc_pkg::KIND_SQUARE;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic logic [7:0] open_char(input logic [1:0] k);
      case (k)
         bbc_pkg::KIND_CURLY:  return bbc_pkg::CHAR_OCURLY;
         bbc_pkg::KIND_SQUARE: return bbc_pkg::CHAR_OSQUARE;
         default:              return bbc_pkg::CHAR_OROUND;
      endcase
   endfunction

   function automatic logic [7:0] close_char(input logic [1:0] k);
      case (k)
         bbc_pkg::KIND_CURLY:  return bbc_pkg::CHAR_CCURLY;
         bbc_pkg::KIND_SQUARE: return bbc_pkg::CHAR_CSQUARE;
         default:              return bbc_pkg::CHAR_CROUND;
      endcase
   endfunction

   function automatic logic [7:0] any_bracket();
      logic [1:0] k;
      k = 2'($urandom_range(2));
      return $urandom_range(1) ? open_char(k) : close_char(k);
   endfunction

   function automatic logic [7:0] filler();
      logic [7:0] c;
      logic [1:0] k;
      do c = 8'($urandom_range(1, 255));
      while (opener_kind(c, k) || closer_kind(c, k));
      return c;
   endfunction

   // Bracket stack model; returns 1 when the character ends a string.
   function automatic bit judge_char(input logic [7:0] c, output verdict_type v);
      logic [1:0] k;
      v = '0;
      if (c == bbc_pkg::CHAR_NUL) begin
         v.balanced   = !clash_seen && !spill_seen && held_count == 0;
         v.overflowed = spill_seen;
         held_count = 0;
         clash_seen = 1'b0;
         spill_seen = 1'b0;
         return 1'b1;
      end
      if (opener_kind(c, k)) begin
         if (held_count >= NEST_LIMIT) begin
            spill_seen = 1'b1;
         end else begin
            held_kind[held_count] = k;
            held_count++;
         end
      end else if (closer_kind(c, k)) begin
         if (held_count == 0) begin
            clash_seen = 1'b1;
         end else begin
            held_count--;
            if (held_kind[held_count] != k) clash_seen = 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic note_failure(input string what);
      if (errors < 10) $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   task automatic send_item(input logic [7:0] c, input bit typed, input bit t_bal,
                            input bit t_ovf);
      verdict_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= c;
      do @(posedge clock);
      while (req_stall);
      if (judge_char(c, v)) begin
         if (typed) begin
            v.balanced   = t_bal;
            v.overflowed = t_ovf;
         end
         verdicts.push_back(v);
      end
      beats_sent++;
   endtask

   task automatic send_char(input logic [7:0] c);
      send_item(c, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic send_deep(input int levels, input bit typed, input bit t_bal,
                            input bit t_ovf);
      logic [1:0] opened [$];
      logic [1:0] k;
      for (int i = 0; i < levels; i++) begin
         k = 2'($urandom_range(2));
         opened.push_back(k);
         send_char(open_char(k));
      end
      while (opened.size() > 0) send_char(close_char(opened.pop_back()));
      send_item(bbc_pkg::CHAR_NUL, typed, t_bal, t_ovf);
   endtask

   task automatic send_random_string();
      logic [1:0] opened [$];
      logic [1:0] k;
      int roll, pick, steps, cap, flaws;
      roll  = $urandom_range(99);
      flaws = (roll >= 70 && roll < 85) ? $urandom_range(1, 2) : 0;
      if (roll < 85) begin
         steps = $urandom_range(0, 20);
         cap   = $urandom_range(1, 12);
         for (int i = 0; i < steps; i++) begin
            if (flaws > 0 && $urandom_range(steps) == 0) begin
               send_char(any_bracket());
               flaws--;
            end
            pick = $urandom_range(9);
            if (pick < 2) begin
               send_char(filler());
            end else if (pick < 6 && opened.size() < cap) begin
               k = 2'($urandom_range(2));
               opened.push_back(k);
               send_char(open_char(k));
            end else if (opened.size() > 0) begin
               send_char(close_char(opened.pop_back()));
            end
         end
         while (opened.size() > 0) send_char(close_char(opened.pop_back()));
         if (flaws > 0) send_char(any_bracket());
      end else begin
         steps = $urandom_range(0, 16);
         for (int i = 0; i < steps; i++)
            send_char($urandom_range(2) == 0 ? filler() : any_bracket());
      end
      send_char(bbc_pkg::CHAR_NUL);
   endtask

   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_req  = 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (verdicts.size() == 0) begin
            note_failure($sformatf("unexpected verdict balanced=%b overflowed=%b",
                                   rsp_balanced, rsp_overflowed));
         end else begin
            want = verdicts.pop_front();
            if (rsp_balanced !== want.balanced || rsp_overflowed !== want.overflowed)
               note_failure($sformatf("balanced exp %b got %b, overflowed exp %b got %b",
                                      want.balanced, rsp_balanced,
                                      want.overflowed, rsp_overflowed));
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].ch, plan[i].typed, plan[i].balanced,
                                  plan[i].overflowed);
      send_deep(NEST_LIMIT, 1'b1, 1'b1, 1'b0);
      send_deep(NEST_LIMIT + 1, 1'b1, 1'b0, 1'b1);
      wait_for_verdicts();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 63 : 0;
         rcv_idle_pct  = (phase == 0) ? 63 : (phase == 1) ? 11 : 0;
         send_deep($urandom_range(NEST_LIMIT - 8, NEST_LIMIT + 3), 1'b0, 1'b0, 1'b0);
         if (phase == 0) begin
            hold_req = 1'b1;
            repeat (40) send_random_string();
         end
         while (beats_sent < (phase + 1) * ITEM_BUDGET / 3) send_random_string();
         wait_for_verdicts();
      end

      repeat (8) @(posedge clock);
      if (verdicts.size() != 0) note_failure("verdicts never delivered");
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
